/* rtl/mrsnp_pkg.sv */
// Package for the motor run/stop needle positioner.
// Types, state codes and constants shared by the core and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mrsnp_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int MSLIM_WIDTH = 16;
    localparam int MODE_WIDTH  = 2;
    localparam int CFG_WIDTH   = (SPEED_WIDTH > MSLIM_WIDTH) ? SPEED_WIDTH : MSLIM_WIDTH;
    localparam int CFG_IDX_W   = 2;

    localparam int IN_BITS     = 2 * SPEED_WIDTH + 2 + TIME_WIDTH;
    localparam int IN_BYTES_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 3 + 1 + 1 + SPEED_WIDTH + 1;
    localparam int OUT_BYTES_W = ((OUT_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POS_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_MODE  = 2'd2;

    // stop modes
    localparam logic [MODE_WIDTH-1:0] MODE_UP   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_DOWN = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_ANY  = 2'd2;

    localparam logic [SPEED_WIDTH-1:0] POS_SPEED_RST  = SPEED_WIDTH'(100);
    localparam logic [MSLIM_WIDTH-1:0] MAX_POS_MS_RST = 16'd1000;

    typedef enum logic [2:0] {
        ST_STOP        = 3'd0,
        ST_STARTING    = 3'd1,
        ST_RUNNING     = 3'd2,
        ST_STOPPING    = 3'd3,
        ST_STARTPOS    = 3'd4,
        ST_POSITIONING = 3'd5
    } run_state_t;

    typedef struct packed {
        logic [SPEED_WIDTH-1:0] speed_req;
        logic [SPEED_WIDTH-1:0] motor_speed;
        logic                   needle_up;
        logic                   needle_down;
        logic [TIME_WIDTH-1:0]  now_ms;
    } in_item_t;

    typedef struct packed {
        logic [SPEED_WIDTH-1:0] hold_speed;
        logic [MSLIM_WIDTH-1:0] max_positioning_ms;
        logic [MODE_WIDTH-1:0]  stop_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]             machine_state;
        logic                   motor_power;
        logic                   spin_valid;
        logic [SPEED_WIDTH-1:0] spin_speed;
        logic                   timeout_error;
    } result_t;

endpackage

/* rtl/mrsnp_core.sv */
// Run/stop state machine with needle positioning for one poll tick per step.
// Holds the controller state; depends on mrsnp_pkg.
`timescale 1ns / 1ps

module mrsnp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mrsnp_pkg::in_item_t item,
    input  mrsnp_pkg::cfg_t   cfg,
    output mrsnp_pkg::result_t result
);
    import mrsnp_pkg::*;

    run_state_t             state_reg, state_next;
    logic [SPEED_WIDTH-1:0] last_cmd_reg, last_cmd_next;
    logic [TIME_WIDTH-1:0]  pos_start_reg, pos_start_next;
    logic                   power_reg, power_next;

    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   spin_valid;
    logic [SPEED_WIDTH-1:0] spin_speed;
    logic                   err;
    logic                   target_nz;
    logic                   halt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_STOP;
            last_cmd_reg  <= '0;
            pos_start_reg <= '0;
            power_reg     <= 1'b0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            last_cmd_reg  <= last_cmd_next;
            pos_start_reg <= pos_start_next;
            power_reg     <= power_next;
        end
    end

    assign target_nz = (item.speed_req != '0);
    assign elapsed   = item.now_ms - pos_start_reg;   // wraps mod 2^32

    always_comb
    begin
        state_next     = state_reg;
        last_cmd_next  = last_cmd_reg;
        pos_start_next = pos_start_reg;
        power_next     = power_reg;
        spin_valid     = 1'b0;
        spin_speed     = '0;
        err            = 1'b0;
        halt           = 1'b1;
        case (state_reg)
            ST_STARTING:
            begin
                power_next = 1'b1;
                state_next = ST_RUNNING;
            end
            ST_RUNNING:
            begin
                if (last_cmd_reg != item.speed_req)
                begin
                    last_cmd_next = item.speed_req;
                    spin_valid    = 1'b1;
                    spin_speed    = item.speed_req;
                end
                if (!target_nz)
                    state_next = ST_STOPPING;
            end
            ST_STOPPING:
            begin
                if (target_nz)
                    state_next = ST_RUNNING;
                else if (item.motor_speed <= cfg.hold_speed)
                    state_next = ST_STARTPOS;
            end
            ST_STARTPOS:
            begin
                pos_start_next = item.now_ms;
                state_next     = ST_POSITIONING;
            end
            ST_POSITIONING:
            begin
                if (target_nz)
                    state_next = ST_RUNNING;
                else
                begin
                    if (cfg.stop_mode != MODE_ANY)
                    begin
                        if (elapsed > {{(TIME_WIDTH-MSLIM_WIDTH){1'b0}},
                                       cfg.max_positioning_ms})
                            err = 1'b1;
                        else if ((cfg.stop_mode == MODE_DOWN && !item.needle_down) ||
                                 (cfg.stop_mode == MODE_UP && !item.needle_up))
                            halt = 1'b0;
                    end
                    spin_valid = 1'b1;
                    if (halt)
                    begin
                        power_next = 1'b0;
                        state_next = ST_STOP;
                    end
                    else
                        spin_speed = cfg.hold_speed;
                end
            end
            default:
            begin
                state_next = target_nz ? ST_STARTING : ST_STOP;
            end
        endcase
    end

    assign result.machine_state = state_next;
    assign result.motor_power   = power_next;
    assign result.spin_valid    = spin_valid;
    assign result.spin_speed    = spin_speed;
    assign result.timeout_error = err;

endmodule

/* rtl/motor_run_stop_needle_positioner.sv */
// Top level of the motor run/stop needle positioner: stream ports, input and
// result registers, configuration registers. Uses mrsnp_pkg and mrsnp_core.
`timescale 1ns / 1ps

// One poll tick per input transfer, one result transfer per tick. A tick is
// registered on input and, through the state machine, in the result register
// when free or draining; a new tick is taken every cycle while the result side
// keeps draining. Configuration (0 positioning speed, 1 positioning time limit
// in ms, 2 stop mode) must be written via cfg_wr_en/cfg_index/cfg_wdata only
// while no tick is in flight; the block itself does not enforce this.
module motor_run_stop_needle_positioner (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [mrsnp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrsnp_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // speed_req[15:0], motor_speed[31:16], needle_up[32], needle_down[33],
    // now_ms[65:34], zero pad
    input  logic [mrsnp_pkg::IN_BYTES_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // machine_state[2:0], motor_power[3], spin_valid[4], spin_speed[20:5],
    // timeout_error[21], zero pad
    output logic [mrsnp_pkg::OUT_BYTES_W-1:0]    m_axis_tdata
);
    import mrsnp_pkg::*;

    cfg_t     cfg_reg;
    in_item_t in_reg;
    logic     in_valid_reg;
    result_t  out_reg;
    logic     out_valid_reg;
    result_t  result;
    logic     advance;

    // item moves from input register to result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_speed         <= POS_SPEED_RST;
            cfg_reg.max_positioning_ms <= MAX_POS_MS_RST;
            cfg_reg.stop_mode          <= MODE_ANY;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POS_SPEED:  cfg_reg.hold_speed         <= cfg_wdata[SPEED_WIDTH-1:0];
                REG_MAX_POS_MS: cfg_reg.max_positioning_ms <= cfg_wdata[MSLIM_WIDTH-1:0];
                REG_STOP_MODE:  cfg_reg.stop_mode          <= cfg_wdata[MODE_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg.speed_req    <= s_axis_tdata[SPEED_WIDTH-1:0];
            in_reg.motor_speed  <= s_axis_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH];
            in_reg.needle_up    <= s_axis_tdata[2*SPEED_WIDTH];
            in_reg.needle_down  <= s_axis_tdata[2*SPEED_WIDTH+1];
            in_reg.now_ms       <= s_axis_tdata[IN_BITS-1:2*SPEED_WIDTH+2];
        end
        if (advance)
            out_reg <= result;
    end

    mrsnp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_BYTES_W-OUT_BITS){1'b0}},
                            out_reg.timeout_error,
                            out_reg.spin_speed,
                            out_reg.spin_valid,
                            out_reg.motor_power,
                            out_reg.machine_state};

endmodule

/* verif/mrsnp_tb_pkg.sv */
// Scoreboard for the motor run/stop needle positioner testbench.
// Predicts one result per poll tick and checks the result stream in order.
// Depends on mrsnp_pkg.
`timescale 1ns / 1ps

package mrsnp_tb_pkg;

    import mrsnp_pkg::*;

    class positioner_scoreboard;

        // configuration copy
        logic [SPEED_WIDTH-1:0] pos_speed;
        logic [MSLIM_WIDTH-1:0] max_pos_ms;
        logic [MODE_WIDTH-1:0]  stop_mode;

        // controller state copy
        run_state_t             state;
        logic [SPEED_WIDTH-1:0] last_cmd;
        logic [TIME_WIDTH-1:0]  pos_start_ms;
        logic                   power;

        result_t                expected_results[$];
        int unsigned            mismatches;

        function new();
            pos_speed    = POS_SPEED_RST;
            max_pos_ms   = MAX_POS_MS_RST;
            stop_mode    = MODE_ANY;
            state        = ST_STOP;
            last_cmd     = '0;
            pos_start_ms = '0;
            power        = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] value);
            case (idx)
                REG_POS_SPEED:  pos_speed  = value[SPEED_WIDTH-1:0];
                REG_MAX_POS_MS: max_pos_ms = value[MSLIM_WIDTH-1:0];
                REG_STOP_MODE:  stop_mode  = value[MODE_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // advance the controller by one tick and queue what it should emit
        function void note_tick(in_item_t t);
            result_t               r;
            logic                  halt;
            logic [TIME_WIDTH-1:0] elapsed;
            r = '0;
            case (state)
                ST_STARTING:
                begin
                    power = 1'b1;
                    state = ST_RUNNING;
                end
                ST_RUNNING:
                begin
                    if (last_cmd != t.speed_req)
                    begin
                        last_cmd     = t.speed_req;
                        r.spin_valid = 1'b1;
                        r.spin_speed = t.speed_req;
                    end
                    if (t.speed_req == '0)
                        state = ST_STOPPING;
                end
                ST_STOPPING:
                begin
                    if (t.speed_req != '0)
                        state = ST_RUNNING;
                    else if (t.motor_speed <= pos_speed)
                        state = ST_STARTPOS;
                end
                ST_STARTPOS:
                begin
                    pos_start_ms = t.now_ms;
                    state        = ST_POSITIONING;
                end
                ST_POSITIONING:
                begin
                    if (t.speed_req != '0)
                        state = ST_RUNNING;
                    else
                    begin
                        halt = 1'b1;
                        if (stop_mode != MODE_ANY)
                        begin
                            // elapsed time wraps with the ms counter
                            elapsed = t.now_ms - pos_start_ms;
                            if (elapsed > max_pos_ms)
                                r.timeout_error = 1'b1;
                            else if ((stop_mode == MODE_DOWN && !t.needle_down) ||
                                     (stop_mode == MODE_UP && !t.needle_up))
                                halt = 1'b0;
                        end
                        r.spin_valid = 1'b1;
                        if (halt)
                        begin
                            power = 1'b0;
                            state = ST_STOP;
                        end
                        else
                            r.spin_speed = pos_speed;
                    end
                end
                default:
                begin
                    state = (t.speed_req != '0) ? ST_STARTING : ST_STOP;
                end
            endcase
            r.machine_state = state;
            r.motor_power   = power;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_BYTES_W-1:0] d);
            result_t got;
            result_t want;
            got.machine_state = d[2:0];
            got.motor_power   = d[3];
            got.spin_valid    = d[4];
            got.spin_speed    = d[5 +: SPEED_WIDTH];
            got.timeout_error = d[5 + SPEED_WIDTH];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer, data %h", d);
                return;
            end
            want = expected_results.pop_front();
            if (got.machine_state !== want.machine_state ||
                got.motor_power   !== want.motor_power   ||
                got.spin_valid    !== want.spin_valid    ||
                got.spin_speed    !== want.spin_speed    ||
                got.timeout_error !== want.timeout_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch exp/act: state %0d/%0d power %0b/%0b ",
                              "spin_valid %0b/%0b spin_speed %0d/%0d timeout %0b/%0b"},
                             want.machine_state, got.machine_state,
                             want.motor_power, got.motor_power,
                             want.spin_valid, got.spin_valid,
                             want.spin_speed, got.spin_speed,
                             want.timeout_error, got.timeout_error);
            end
        endfunction

    endclass

endpackage

/* verif/tb_motor_run_stop_needle_positioner.sv */
// Testbench top for motor_run_stop_needle_positioner: directed and state-aware
// random poll ticks over several configurations, checked by the scoreboard.
// Depends on mrsnp_pkg, mrsnp_tb_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_motor_run_stop_needle_positioner;

    import mrsnp_pkg::*;
    import mrsnp_tb_pkg::*;

    localparam logic [MODE_WIDTH-1:0] MODE_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_TICKS  = 180;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_WIDTH-1:0]   cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;

    positioner_scoreboard   sb;
    logic [TIME_WIDTH-1:0]  ms_clock = 32'hFFFF_FF00;
    logic [SPEED_WIDTH-1:0] last_target = '0;
    bit                     snd_idle = 1'b1;
    bit                     rcv_idle = 1'b1;
    int                     hold_left = 0;
    int                     stall_left = 0;
    int unsigned            cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    motor_run_stop_needle_positioner u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // result side: long hold-off first, then the per-transfer stall
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_motor_run_stop_needle_positioner: done, errors");
            $finish;
        end
        else if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
            stall_left = rcv_idle ? int'($urandom_range(0, 5)) : 0;
        end
    end

    function automatic logic [IN_BYTES_W-1:0] pack_tick(in_item_t t);
        logic [IN_BYTES_W-1:0] v;
        v = '0;
        v[SPEED_WIDTH-1:0]             = t.speed_req;
        v[SPEED_WIDTH +: SPEED_WIDTH]  = t.motor_speed;
        v[2*SPEED_WIDTH]               = t.needle_up;
        v[2*SPEED_WIDTH+1]             = t.needle_down;
        v[2*SPEED_WIDTH+2 +: TIME_WIDTH] = t.now_ms;
        return v;
    endfunction

    function automatic logic [SPEED_WIDTH-1:0] pick_speed();
        case ($urandom_range(0, 3))
            0: return SPEED_WIDTH'(1);
            1: return '1;
            2: return SPEED_WIDTH'($urandom_range(1, 400));
            default: return SPEED_WIDTH'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic send_tick(logic [SPEED_WIDTH-1:0] target, logic [SPEED_WIDTH-1:0] motor,
                             logic up, logic down);
        in_item_t t;
        int       gap;
        t.speed_req    = target;
        t.motor_speed  = motor;
        t.needle_up    = up;
        t.needle_down  = down;
        t.now_ms       = ms_clock;
        last_target    = target;
        gap = snd_idle ? int'($urandom_range(0, 5)) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_tick(t);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_tick(t);
    endtask

    task automatic drive_tick(logic [SPEED_WIDTH-1:0] target, logic [SPEED_WIDTH-1:0] motor,
                              logic up, logic down);
        ms_clock += TIME_WIDTH'(3);
        send_tick(target, motor, up, down);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // fields are drawn from the predicted state so most ticks walk the full
    // start / run / coast / position cycle; a few are pure noise
    task automatic random_tick();
        logic [SPEED_WIDTH-1:0] target;
        logic [SPEED_WIDTH-1:0] motor;
        logic                   up;
        logic                   down;
        int unsigned            roll;
        roll   = $urandom_range(0, 99);
        target = '0;
        motor  = SPEED_WIDTH'($urandom);
        up     = ($urandom_range(0, 3) == 0);
        down   = ($urandom_range(0, 3) == 0);
        ms_clock += TIME_WIDTH'($urandom_range(0, 20));
        if (roll < 5)
        begin
            target   = SPEED_WIDTH'($urandom);
            up       = ($urandom_range(0, 1) == 1);
            down     = ($urandom_range(0, 1) == 1);
            ms_clock = TIME_WIDTH'($urandom);
        end
        else
        begin
            case (sb.state)
                ST_STOP, ST_STARTING:
                    target = (roll < 30) ? '0 : pick_speed();
                ST_RUNNING:
                begin
                    if (roll < 25)
                        target = '0;
                    else if (roll < 65)
                        target = last_target;
                    else
                        target = pick_speed();
                end
                ST_STOPPING:
                begin
                    if (roll < 12)
                        target = pick_speed();
                    if ($urandom_range(0, 1) == 1 && sb.pos_speed != '1)
                        motor = SPEED_WIDTH'($urandom_range(sb.pos_speed + 1, 65535));
                    else
                        motor = SPEED_WIDTH'($urandom_range(0, sb.pos_speed));
                end
                ST_STARTPOS:
                begin
                    if (roll < 8)
                        target = pick_speed();
                end
                ST_POSITIONING:
                begin
                    if (roll < 8)
                        target = pick_speed();
                    // land right on the time limit or one past it
                    case ($urandom_range(0, 5))
                        0: ms_clock = sb.pos_start_ms + sb.max_pos_ms;
                        1: ms_clock = sb.pos_start_ms + sb.max_pos_ms + 1;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        send_tick(target, motor, up, down);
    endtask

    task automatic run_phase(logic [CFG_WIDTH-1:0] pos, logic [CFG_WIDTH-1:0] max_ms,
                             logic [CFG_WIDTH-1:0] mode, bit sidle, bit ridle,
                             bit hold, bit pause_mid);
        wait_drain();
        write_reg(REG_POS_SPEED, pos);
        write_reg(REG_MAX_POS_MS, max_ms);
        write_reg(REG_STOP_MODE, mode);
        @(posedge clk);
        snd_idle = sidle;
        rcv_idle = ridle;
        if (hold)
            hold_left = HOLD_CYCLES;
        for (int i = 0; i < PHASE_TICKS; i++)
        begin
            random_tick();
            if (pause_mid && i == PHASE_TICKS / 2)
                wait_drain();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: stop mode don't care, positioning speed 100
        drive_tick('0, '0, 1'b0, 1'b0);
        drive_tick('1, '1, 1'b1, 1'b1);
        drive_tick('1, '0, 1'b0, 1'b0);
        drive_tick('1, '0, 1'b0, 1'b0);
        drive_tick('1, '0, 1'b0, 1'b0);
        drive_tick(16'd1, 16'd500, 1'b0, 1'b0);
        drive_tick('0, '1, 1'b0, 1'b0);
        drive_tick('0, '1, 1'b0, 1'b0);
        // target comes back while coasting
        drive_tick(16'd7, 16'd200, 1'b0, 1'b0);
        drive_tick(16'd7, 16'd200, 1'b0, 1'b0);
        drive_tick('0, 16'd101, 1'b0, 1'b0);
        drive_tick('0, 16'd100, 1'b0, 1'b0);
        drive_tick('0, '0, 1'b0, 1'b0);
        // target comes back while positioning
        drive_tick(16'd3, '0, 1'b1, 1'b0);
        drive_tick('0, '0, 1'b0, 1'b0);
        drive_tick('0, 16'd50, 1'b0, 1'b0);
        drive_tick('0, '0, 1'b0, 1'b1);
        drive_tick('0, '0, 1'b0, 1'b0);

        run_phase(16'hFFFF, 16'd0, MODE_UP, 1'b1, 1'b1, 1'b0, 1'b0);
        run_phase(16'd0, 16'hFFFF, MODE_DOWN, 1'b0, 1'b0, 1'b1, 1'b0);
        run_phase(16'd100, 16'd1000, MODE_ANY, 1'b1, 1'b1, 1'b0, 1'b1);
        run_phase(16'd300, 16'd20, {{(CFG_WIDTH-MODE_WIDTH){1'b1}}, MODE_RESERVED},
                  1'b1, 1'b1, 1'b0, 1'b0);
        for (int p = 0; p < 4; p++)
            run_phase(CFG_WIDTH'($urandom_range(0, 2000)),
                      CFG_WIDTH'($urandom_range(0, 200)),
                      CFG_WIDTH'($urandom_range(0, 3)), 1'b1, (p != 1), 1'b0, 1'b0);

        wait_drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_motor_run_stop_needle_positioner: done, clean");
        else
            $display("tb_motor_run_stop_needle_positioner: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/mrsnp_pkg.sv
rtl/mrsnp_core.sv
rtl/motor_run_stop_needle_positioner.sv
verif/mrsnp_tb_pkg.sv
verif/tb_motor_run_stop_needle_positioner.sv
